>>> hw/rtl/delimited_frame_receiver_checksum_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimited frame receiver
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFRC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame receiver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DFRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame receiver assertion failed");

`endif

>>> hw/rtl/dfrc_pkg.sv
// ----------------------------------------------------------------------------
// dfrc_pkg
// Types, codes and character helpers shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package dfrc_pkg;

	localparam logic [1:0] CMD_BYTE   = 2'd0;
	localparam logic [1:0] CMD_ARM    = 2'd1;
	localparam logic [1:0] CMD_DISARM = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USECS = 2'd3;

	localparam logic [7:0] RST_START = 8'd2;
	localparam logic [7:0] RST_END   = 8'd3;
	localparam logic [7:0] RST_DELIM = 8'd124;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIG,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic walk;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic walk_end;
		logic out_free;
	} stat_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

>>> hw/rtl/dfrc_ctrl.sv
// ----------------------------------------------------------------------------
// dfrc_ctrl
// Sequencer: takes a beat, runs the command, walks the stores, posts the result.
// ----------------------------------------------------------------------------
`include "delimited_frame_receiver_checksum_assert.svh"

module dfrc_ctrl
	import dfrc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		ctrl = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.latch_in = 1'b1;
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_n = ST_WALK;
			end
			ST_WALK: begin
				ctrl.walk = 1'b1;
				if (stat.walk_end) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.finish = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	`DFRC_ASSERT_NEXT(a_accept_then_exec, s_tvalid && s_tready, ctrl.exec)
	`DFRC_ASSERT_NEXT(a_exec_then_walk, ctrl.exec, ctrl.walk)
	`DFRC_ASSERT_NEXT(a_walk_stops, ctrl.walk && stat.walk_end, !ctrl.walk && !s_tready)
	`DFRC_ASSERT_NEXT(a_finish_then_ready, ctrl.finish, s_tready)

endmodule

>>> hw/rtl/dfrc_dpath.sv
// ----------------------------------------------------------------------------
// dfrc_dpath
// Capture stores, frame flags, checksum accumulator and field parser.
// ----------------------------------------------------------------------------
module dfrc_dpath
	import dfrc_pkg::*;
#(
	parameter int MSG_LEN  = 32,
	parameter int CSUM_LEN = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	output stat_t                stat,
	input  logic [1:0]           in_cmd,
	input  logic [7:0]           in_byte,
	input  logic [4:0]           in_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]           cfg_wdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          out_data
);

	localparam int NW  = (MSG_LEN - 1 > CSUM_LEN - 1) ? MSG_LEN - 1 : CSUM_LEN - 1;
	localparam int CW  = $clog2(NW + 1);
	localparam int AW  = $clog2(MSG_LEN);
	localparam int PW  = $clog2(CSUM_LEN);
	localparam int IXW = 8;

	logic [1:0]  cmd_q;
	logic [7:0]  byte_q;
	logic [4:0]  idx_q;

	logic [7:0]  start_q;
	logic [7:0]  end_q;
	logic [7:0]  delim_q;
	logic        usecs_q;

	logic [7:0]  mem_q [MSG_LEN];
	logic [MSG_LEN-1:0] vld_q;
	logic [7:0]  cs_q [CSUM_LEN];

	logic [AW-1:0] mpos_q;
	logic [PW-1:0] cpos_q;
	logic        in_msg_q;
	logic        in_cs_q;
	logic        done_q;
	logic        rxen_q;
	logic        acc_q;

	logic [CW-1:0] cnt_q;
	logic [15:0] sum_q;
	logic [15:0] val_q;
	logic        neg_q;
	phase_t      phase_q;

	logic [7:0]  rdat_s1;
	logic        rvld_s1;
	logic        rlast_s1;
	logic [7:0]  rd_q;

	logic        ovalid_q;
	logic [15:0] odata_q;

	logic        is_end;
	logic        is_start;
	logic        is_delim;
	logic        take;
	logic        capture;
	logic        mem_we;
	logic        cs_we;
	logic        idx_ok;
	logic [AW-1:0] rd_addr;
	logic [7:0]  eff_byte;
	logic        sum_en;
	logic        parse_en;
	logic [PW-1:0] pidx;
	logic [7:0]  pch;
	logic [15:0] val_n;
	logic        neg_n;
	phase_t      phase_n;
	logic [15:0] field;
	logic [15:0] total;
	logic        csum_ok;

	always_comb begin
		is_end   = (byte_q == end_q);
		is_start = (byte_q == start_q);
		is_delim = (byte_q == delim_q) && usecs_q;
		take     = ctrl.exec && (cmd_q == CMD_BYTE) && rxen_q && !done_q;
		capture  = take && !is_end && !is_start && !is_delim;
		mem_we   = capture && in_msg_q;
		cs_we    = capture && !in_msg_q && in_cs_q;
		idx_ok   = (IXW'(idx_q) < IXW'(MSG_LEN));
		if (ctrl.exec) begin
			rd_addr = idx_ok ? AW'(idx_q) : '0;
		end else begin
			rd_addr = (cnt_q <= CW'(MSG_LEN - 1)) ? cnt_q[AW-1:0] : '0;
		end
		eff_byte = rvld_s1 ? rdat_s1 : (rlast_s1 ? CH_NUL : CH_SPACE);
		sum_en   = ctrl.walk && (cnt_q != '0) && (cnt_q <= CW'(MSG_LEN - 1));
		parse_en = ctrl.walk && ({1'b0, cnt_q} < (CW + 1)'(CSUM_LEN));
		pidx     = parse_en ? cnt_q[PW-1:0] : '0;
		pch      = cs_q[pidx];
	end

	always_comb begin
		val_n   = val_q;
		neg_n   = neg_q;
		phase_n = phase_q;
		unique case (phase_q)
			PH_SKIP: begin
				if (is_blank(pch)) begin
					phase_n = PH_SKIP;
				end else if ((pch == CH_PLUS) || (pch == CH_MINUS)) begin
					neg_n   = (pch == CH_MINUS);
					phase_n = PH_DIG;
				end else if (is_digit(pch)) begin
					val_n   = {12'd0, pch[3:0]};
					phase_n = PH_DIG;
				end else begin
					phase_n = PH_STOP;
				end
			end
			PH_DIG: begin
				if (is_digit(pch)) begin
					val_n = (val_q << 3) + (val_q << 1) + {12'd0, pch[3:0]};
				end else begin
					phase_n = PH_STOP;
				end
			end
			PH_STOP: begin
				phase_n = PH_STOP;
			end
			default: begin
				phase_n = PH_STOP;
			end
		endcase
	end

	always_comb begin
		field   = neg_q ? (~val_q + 16'd1) : val_q;
		total   = sum_q + field;
		csum_ok = !usecs_q || (total == 16'd0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch_in) begin
			cmd_q  <= in_cmd;
			byte_q <= in_byte;
			idx_q  <= in_index;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mpos_q] <= byte_q;
		end
		rdat_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= RST_START;
			end_q    <= RST_END;
			delim_q  <= RST_DELIM;
			usecs_q  <= 1'b1;
			vld_q    <= '0;
			for (int i = 0; i < CSUM_LEN; i++) begin
				cs_q[i] <= (i == CSUM_LEN - 1) ? CH_NUL : CH_SPACE;
			end
			mpos_q   <= '0;
			cpos_q   <= '0;
			in_msg_q <= 1'b0;
			in_cs_q  <= 1'b0;
			done_q   <= 1'b0;
			rxen_q   <= 1'b0;
			acc_q    <= 1'b0;
			rvld_s1  <= 1'b0;
			rlast_s1 <= 1'b0;
		end else begin
			rvld_s1  <= vld_q[rd_addr];
			rlast_s1 <= (rd_addr == AW'(MSG_LEN - 1));

			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_START: start_q <= cfg_wdata;
					CFG_END:   end_q   <= cfg_wdata;
					CFG_DELIM: delim_q <= cfg_wdata;
					CFG_USECS: usecs_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			if (ctrl.exec) begin
				acc_q <= take;
				unique case (cmd_q)
					CMD_BYTE: begin
						if (rxen_q && done_q) begin
							rxen_q <= 1'b0;
						end
					end
					CMD_ARM: begin
						rxen_q <= 1'b1;
						done_q <= 1'b0;
						vld_q  <= '0;
						for (int i = 0; i < CSUM_LEN; i++) begin
							cs_q[i] <= (i == CSUM_LEN - 1) ? CH_NUL : CH_SPACE;
						end
					end
					CMD_DISARM: begin
						rxen_q <= 1'b0;
						done_q <= 1'b0;
					end
					CMD_READ: ;
					default: ;
				endcase

				if (take) begin
					priority if (is_end) begin
						mpos_q   <= '0;
						cpos_q   <= '0;
						in_msg_q <= 1'b0;
						in_cs_q  <= 1'b0;
						done_q   <= 1'b1;
					end else if (is_start) begin
						mpos_q   <= '0;
						cpos_q   <= '0;
						in_msg_q <= 1'b1;
						in_cs_q  <= 1'b0;
						done_q   <= 1'b0;
					end else if (is_delim) begin
						cpos_q   <= '0;
						in_msg_q <= 1'b0;
						in_cs_q  <= 1'b1;
						done_q   <= 1'b0;
					end else if (in_msg_q) begin
						vld_q[mpos_q] <= 1'b1;
						if (mpos_q != AW'(MSG_LEN - 1)) begin
							mpos_q <= mpos_q + 1'b1;
						end else begin
							mpos_q <= '0;
							cpos_q <= '0;
							if (!usecs_q) begin
								in_msg_q <= 1'b0;
								in_cs_q  <= 1'b0;
								done_q   <= 1'b1;
							end
						end
					end else if (in_cs_q) begin
						if (cs_we) begin
							cs_q[cpos_q] <= byte_q;
						end
						if (cpos_q != PW'(CSUM_LEN - 1)) begin
							cpos_q <= cpos_q + 1'b1;
						end else begin
							mpos_q   <= '0;
							cpos_q   <= '0;
							in_msg_q <= 1'b0;
							in_cs_q  <= 1'b0;
							done_q   <= 1'b1;
						end
					end else begin
						done_q <= done_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			cnt_q   <= '0;
			sum_q   <= 16'd0;
			val_q   <= 16'd0;
			neg_q   <= 1'b0;
			phase_q <= PH_SKIP;
		end else if (ctrl.walk) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '0) begin
				rd_q <= ((cmd_q == CMD_READ) && idx_ok) ? eff_byte : 8'd0;
			end
			if (sum_en) begin
				sum_q <= sum_q + {{8{eff_byte[7]}}, eff_byte};
			end
			if (parse_en) begin
				val_q   <= val_n;
				neg_q   <= neg_n;
				phase_q <= phase_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctrl.finish) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			odata_q <= {4'd0, rd_q, rxen_q, csum_ok, done_q, acc_q};
		end
	end

	assign stat.walk_end = (cnt_q == CW'(NW));
	assign stat.out_free = !ovalid_q || out_ready;
	assign out_valid     = ovalid_q;
	assign out_data      = odata_q;

endmodule

>>> hw/rtl/delimited_frame_receiver_checksum.sv
// ----------------------------------------------------------------------------
// delimited_frame_receiver_checksum: framed byte receiver with additive checksum
// Each accepted beat is executed, then the stores are walked, one entry per cycle,
// and the result is posted once the output is free; no new beat is taken until
// the result of the last one has been posted.
// Reset clears all flags; the stores read as spaces with a final zero at once.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_checksum
	import dfrc_pkg::*;
#(
	parameter int MSG_LEN  = 32,
	parameter int CSUM_LEN = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // data_byte [7:0], read_index [12:8], zero
	input  logic [1:0]           s_tuser,   // cmd [1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // accepted, frame_ready, checksum_ok, armed,
	                                        // read_byte [11:4], zero
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	dfrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	dfrc_dpath #(
		.MSG_LEN  (MSG_LEN),
		.CSUM_LEN (CSUM_LEN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_cmd    (s_tuser),
		.in_byte   (s_tdata[7:0]),
		.in_index  (s_tdata[12:8]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> verif/frame_rx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_rx_checker: result checker for the delimited frame receiver
// Follows register writes and accepted item beats, runs its own model of the
// capture state to predict one status per beat, and compares every result
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_rx_checker
	import dfrc_pkg::*;
#(
	parameter int MSG_LEN  = 32,
	parameter int CSUM_LEN = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,   // data_byte [7:0], read_index [12:8], zero
	input  logic [1:0]           s_tuser,   // cmd [1:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,   // accepted, frame_ready, checksum_ok, armed,
	                                        // read_byte [11:4], zero
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [7:0] rd_byte;
		logic       armed;
		logic       sum_ok;
		logic       frame_rdy;
		logic       taken;
	} rx_status_t;

	logic [7:0]  msg_mem [MSG_LEN];
	logic [7:0]  fld_mem [CSUM_LEN];
	int unsigned msg_pos, fld_pos;
	logic        in_msg, in_fld, done, rx_on;
	logic [7:0]  start_c, end_c, delim_c;
	logic        use_sum;
	rx_status_t  rx_status_q [$];
	rx_status_t  want, got;

	function automatic logic blank_char(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	function automatic void blank_stores();
		foreach (msg_mem[i]) msg_mem[i] = CH_SPACE;
		foreach (fld_mem[i]) fld_mem[i] = CH_SPACE;
		msg_mem[MSG_LEN-1] = CH_NUL;
		fld_mem[CSUM_LEN-1] = CH_NUL;
	endfunction

	function automatic void close_frame();
		msg_pos = 0;
		fld_pos = 0;
		in_msg = 1'b0;
		in_fld = 1'b0;
		done = 1'b1;
	endfunction

	// Decimal field: blanks, optional sign, digits up to a non-digit or the store end.
	function automatic logic [15:0] field_value();
		int         i;
		logic [15:0] v;
		logic       neg;
		i = 0;
		v = '0;
		neg = 1'b0;
		while (i < CSUM_LEN && blank_char(fld_mem[i])) i++;
		if (i < CSUM_LEN && (fld_mem[i] == CH_PLUS || fld_mem[i] == CH_MINUS)) begin
			neg = (fld_mem[i] == CH_MINUS);
			i++;
		end
		while (i < CSUM_LEN && (fld_mem[i] inside {[CH_ZERO:CH_NINE]})) begin
			v = v * 16'd10 + 16'(fld_mem[i] - CH_ZERO);
			i++;
		end
		return neg ? 16'(-v) : v;
	endfunction

	function automatic logic frame_sum_ok();
		logic [15:0] acc;
		acc = '0;
		if (!use_sum)
			return 1'b1;
		for (int i = 0; i < MSG_LEN - 1; i++)
			acc = acc + {{8{msg_mem[i][7]}}, msg_mem[i]};
		acc = acc + field_value();
		return acc == 16'd0;
	endfunction

	function automatic void take_char(input logic [7:0] c);
		if (c == end_c) begin
			close_frame();
		end else if (c == start_c) begin
			msg_pos = 0;
			fld_pos = 0;
			in_msg = 1'b1;
			in_fld = 1'b0;
			done = 1'b0;
		end else if (c == delim_c && use_sum) begin
			fld_pos = 0;
			in_msg = 1'b0;
			in_fld = 1'b1;
			done = 1'b0;
		end else if (in_msg) begin
			msg_mem[msg_pos] = c;
			if (msg_pos < MSG_LEN - 1) begin
				msg_pos++;
			end else begin
				msg_pos = 0;
				fld_pos = 0;
				if (!use_sum)
					close_frame();
			end
		end else if (in_fld) begin
			fld_mem[fld_pos] = c;
			if (fld_pos < CSUM_LEN - 1)
				fld_pos++;
			else
				close_frame();
		end
	endfunction

	function automatic rx_status_t predict_status(input logic [1:0] op, input logic [7:0] b,
			input logic [4:0] ri);
		rx_status_t r;
		r = '0;
		case (op)
			CMD_BYTE: begin
				if (rx_on) begin
					if (done) begin
						rx_on = 1'b0;
					end else begin
						take_char(b);
						r.taken = 1'b1;
					end
				end
			end
			CMD_ARM: begin
				rx_on = 1'b1;
				done = 1'b0;
				blank_stores();
			end
			CMD_DISARM: begin
				rx_on = 1'b0;
				done = 1'b0;
			end
			default: begin
				if (ri < MSG_LEN)
					r.rd_byte = msg_mem[ri];
			end
		endcase
		r.frame_rdy = done;
		r.sum_ok = frame_sum_ok();
		r.armed = rx_on;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_c = RST_START;
			end_c = RST_END;
			delim_c = RST_DELIM;
			use_sum = 1'b1;
			blank_stores();
			msg_pos = 0;
			fld_pos = 0;
			in_msg = 1'b0;
			in_fld = 1'b0;
			done = 1'b0;
			rx_on = 1'b0;
			rx_status_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START: start_c = cfg_data;
					CFG_END:   end_c = cfg_data;
					CFG_DELIM: delim_c = cfg_data;
					CFG_USECS: use_sum = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				rx_status_q.push_back(predict_status(s_tuser, s_tdata[7:0], s_tdata[12:8]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[11:0];
				if (rx_status_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Result beat %h arrived with no prediction waiting.", m_tdata);
				end else begin
					want = rx_status_q.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= 10)
							$display({"Status mismatch: expected accepted=%b ready=%b ok=%b ",
								"armed=%b byte=%h, got accepted=%b ready=%b ok=%b armed=%b ",
								"byte=%h"}, want.taken, want.frame_rdy, want.sum_ok,
								want.armed, want.rd_byte, got.taken, got.frame_rdy,
								got.sum_ok, got.armed, got.rd_byte);
					end
				end
			end
			pending = rx_status_q.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the delimited frame receiver
// Drives directed and random frames, noise and store reads through several
// register settings, with bursty input and a stalling result side, and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import dfrc_pkg::*;

	localparam int MSG_LEN   = 32;
	localparam int CSUM_LEN  = 6;
	localparam int PHASE_LEN = 190;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;
	logic [1:0]           s_tuser = CMD_BYTE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
	logic [7:0]           cfg_data = '0;
	int                   errors;
	int                   pending;

	logic [7:0] start_c = RST_START;
	logic [7:0] end_c = RST_END;
	logic [7:0] delim_c = RST_DELIM;
	logic       use_sum = 1'b1;
	int         items = 0;
	int         burst_left = 0;
	logic       quiet = 1'b0;
	logic [8:0] stall_cnt = '0;
	logic [1:0] stall_mode = '0;

	delimited_frame_receiver_checksum #(
		.MSG_LEN  (MSG_LEN),
		.CSUM_LEN (CSUM_LEN)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frame_rx_checker #(
		.MSG_LEN  (MSG_LEN),
		.CSUM_LEN (CSUM_LEN)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cnt <= '0;
			stall_mode <= '0;
			m_tready <= 1'b0;
		end else begin
			stall_cnt <= stall_cnt + 1'b1;
			if (stall_cnt == '0)
				stall_mode <= 2'($urandom_range(0, 3));
			case (stall_mode)
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= (stall_cnt[1:0] == 2'd0);
				default: m_tready <= (stall_cnt[5:0] >= 6'd40);
			endcase
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [7:0] b, input logic [4:0] ri);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		if (op != CMD_BYTE)
			b = 8'($urandom_range(0, 255));
		if (op != CMD_READ)
			ri = 5'($urandom_range(0, 31));
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, ri, b};
		items++;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == start_c || c == end_c || (use_sum && c == delim_c));
		return c;
	endfunction

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] s, input logic [7:0] e,
			input logic [7:0] d, input logic u);
		logic [7:0]           vals [4];
		logic [CFG_IDX_W-1:0] regs [4];
		vals = '{s, e, d, {7'd0, u}};
		regs = '{CFG_START, CFG_END, CFG_DELIM, CFG_USECS};
		start_c = s;
		end_c = e;
		delim_c = d;
		use_sum = u;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frames whose checksum field is right, off by one, wrapped,
	// padded, signed or garbage; the message sometimes runs past the store end.
	task automatic send_frame();
		logic [7:0]  img [MSG_LEN];
		logic [7:0]  fld [$];
		logic [15:0] total;
		logic [15:0] target;
		logic [7:0]  c;
		string       txt;
		int          n;
		int          val;
		for (int i = 0; i < MSG_LEN; i++) img[i] = CH_SPACE;
		img[MSG_LEN-1] = CH_NUL;
		total = '0;
		if ($urandom_range(0, 9) != 0)
			push_item(CMD_ARM, 8'h00, 5'd0);
		repeat ($urandom_range(0, 2)) push_item(CMD_BYTE, plain_char(), 5'd0);
		push_item(CMD_BYTE, start_c, 5'd0);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(MSG_LEN, MSG_LEN + 12)
			: $urandom_range(0, MSG_LEN - 1);
		for (int i = 0; i < n; i++) begin
			c = plain_char();
			img[i % MSG_LEN] = c;
			push_item(CMD_BYTE, c, 5'd0);
		end
		if (use_sum) begin
			for (int i = 0; i < MSG_LEN - 1; i++)
				total = total + {{8{img[i][7]}}, img[i]};
			target = -total;
			push_item(CMD_BYTE, delim_c, 5'd0);
			case ($urandom_range(0, 5))
				0: val = int'(target);
				1: begin
					fld.push_back(CH_MINUS);
					val = int'(total);
				end
				2: begin
					c = ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
					fld.push_back(c);
					fld.push_back(CH_PLUS);
					val = int'(target);
				end
				3: val = int'(target) + 1;
				4: val = (int'(target) + 65536 <= 99999) ? int'(target) + 65536 : int'(target);
				default: val = -1;
			endcase
			if (val >= 0) begin
				txt = $sformatf("%0d", val);
				for (int i = 0; i < txt.len(); i++) fld.push_back(txt[i]);
			end else begin
				repeat ($urandom_range(0, 7)) begin
					case ($urandom_range(0, 3))
						0: c = 8'(CH_ZERO + $urandom_range(0, 9));
						1: c = ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS;
						2: c = CH_SPACE;
						default: c = 8'($urandom_range(0, 255));
					endcase
					fld.push_back(c);
				end
			end
			foreach (fld[i]) push_item(CMD_BYTE, fld[i], 5'd0);
		end
		if ($urandom_range(0, 9) != 0)
			push_item(CMD_BYTE, end_c, 5'd0);
		repeat ($urandom_range(0, 3))
			push_item(CMD_READ, 8'h00, 5'($urandom_range(0, MSG_LEN - 1)));
		case ($urandom_range(0, 5))
			0: push_item(CMD_BYTE, plain_char(), 5'd0);
			1: push_item(CMD_DISARM, 8'h00, 5'd0);
			default: ;
		endcase
	endtask

	initial begin
		logic [7:0] nb;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh stores, a byte while disarmed, a frame with extreme signed bytes
		// and a negative checksum, then a byte after completion.
		push_item(CMD_READ, 8'h00, 5'd0);
		push_item(CMD_READ, 8'h00, 5'd31);
		push_item(CMD_BYTE, RST_START, 5'd0);
		push_item(CMD_DISARM, 8'h00, 5'd0);
		push_item(CMD_ARM, 8'h00, 5'd0);
		push_item(CMD_BYTE, RST_START, 5'd0);
		push_item(CMD_BYTE, 8'hFF, 5'd0);
		push_item(CMD_BYTE, 8'h80, 5'd0);
		push_item(CMD_BYTE, 8'h7F, 5'd0);
		push_item(CMD_BYTE, 8'h01, 5'd0);
		push_item(CMD_BYTE, RST_DELIM, 5'd0);
		push_item(CMD_BYTE, CH_MINUS, 5'd0);
		push_item(CMD_BYTE, CH_ZERO + 8'd8, 5'd0);
		push_item(CMD_BYTE, CH_ZERO + 8'd6, 5'd0);
		push_item(CMD_BYTE, CH_ZERO + 8'd3, 5'd0);
		push_item(CMD_BYTE, RST_END, 5'd0);
		push_item(CMD_READ, 8'h00, 5'd1);
		push_item(CMD_READ, 8'h00, 5'd31);
		push_item(CMD_BYTE, 8'h41, 5'd0);

		// A full checksum field overwrites its terminator and closes the frame.
		push_item(CMD_ARM, 8'h00, 5'd0);
		push_item(CMD_BYTE, RST_START, 5'd0);
		push_item(CMD_BYTE, RST_DELIM, 5'd0);
		for (int k = 1; k <= CSUM_LEN; k++) push_item(CMD_BYTE, CH_ZERO + 8'(k), 5'd0);
		push_item(CMD_BYTE, RST_END, 5'd0);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: apply_settings(8'h00, 8'hFF, 8'h80, 1'b1);
				2: apply_settings(8'hFF, 8'h00, 8'h7C, 1'b0);
				4: apply_settings(RST_START, RST_END, RST_DELIM, 1'b1);
				3, 5: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				default: ;
			endcase
			quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
			while (items < (phase + 1) * PHASE_LEN + 25) begin
				if ($urandom_range(0, 3) != 0) begin
					send_frame();
				end else begin
					case ($urandom_range(0, 3))
						0: nb = start_c;
						1: nb = end_c;
						2: nb = delim_c;
						default: nb = 8'($urandom_range(0, 255));
					endcase
					push_item(2'($urandom_range(0, 3)), nb, 5'($urandom_range(0, 31)));
				end
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** delimited_frame_receiver_checksum: PASSED **");
		else
			$display("** delimited_frame_receiver_checksum: FAILED **");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("** delimited_frame_receiver_checksum: FAILED **");
		$finish;
	end

endmodule
